// File: src/lfbr_pkg.sv
// Shared types and constants of the length-framed byte receiver.
// No dependencies; every other file of the block imports this package.
package lfbr_pkg;

    localparam int DEFAULT_MAX_FRAME = 64;
    localparam int HEADER_BYTES      = 5;
    localparam int LEN_LOW_POS       = 3;

    localparam int REQ_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int INDEX_W     = 6;
    localparam int LENGTH_W    = 7;
    localparam int TIMEOUT_W   = 16;
    localparam int IDLE_W      = 17;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_BYTE = 2'd0,
        REQ_POLL = 2'd1,
        REQ_READ = 2'd2
    } req_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIRST_SYNC  = 4'd0,
        CFG_SECOND_SYNC = 4'd1,
        CFG_MIN_LENGTH  = 4'd2,
        CFG_TIMEOUT     = 4'd3
    } cfg_index_t;

    localparam logic [BYTE_W-1:0]    RST_FIRST_SYNC  = 8'd170;
    localparam logic [BYTE_W-1:0]    RST_SECOND_SYNC = 8'd85;
    localparam logic [LENGTH_W-1:0]  RST_MIN_LENGTH  = 7'd6;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT     = 16'd1000;

    typedef struct packed {
        logic [BYTE_W-1:0]    first_sync;
        logic [BYTE_W-1:0]    second_sync;
        logic [LENGTH_W-1:0]  min_length;
        logic [TIMEOUT_W-1:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic                frame_ready;
        logic [LENGTH_W-1:0] frame_length;
        logic                rd_sel;
    } result_t;

endpackage

// File: src/lfbr_cfg.sv
// Configuration registers of the length-framed byte receiver.
// Depends on lfbr_pkg for the register indexes, reset values and cfg_t.
module lfbr_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lfbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfbr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lfbr_pkg::cfg_t                 cfg
);
    import lfbr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_sync  <= RST_FIRST_SYNC;
            cfg_reg.second_sync <= RST_SECOND_SYNC;
            cfg_reg.min_length  <= RST_MIN_LENGTH;
            cfg_reg.timeout     <= RST_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_SYNC:  cfg_reg.first_sync  <= cfg_data[BYTE_W-1:0];
                CFG_SECOND_SYNC: cfg_reg.second_sync <= cfg_data[BYTE_W-1:0];
                CFG_MIN_LENGTH:  cfg_reg.min_length  <= cfg_data[LENGTH_W-1:0];
                CFG_TIMEOUT:     cfg_reg.timeout     <= cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/lfbr_buf.sv
// Frame buffer memory: one write port and one read port with registered data.
// Depends on lfbr_pkg for the byte width.
module lfbr_buf #(
    parameter int MaxFrame = lfbr_pkg::DEFAULT_MAX_FRAME,
    parameter int AddrW    = $clog2(MaxFrame)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AddrW-1:0]            wr_addr,
    input  logic [lfbr_pkg::BYTE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AddrW-1:0]            rd_addr,
    output logic [lfbr_pkg::BYTE_W-1:0] rd_data
);
    import lfbr_pkg::*;

    logic [BYTE_W-1:0] mem [MaxFrame];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/lfbr_ctrl.sv
// Frame tracking of the receiver: sync check, length header, end of frame,
// held frame and poll timeout. Depends on lfbr_pkg for types and constants.
module lfbr_ctrl #(
    parameter int MaxFrame = lfbr_pkg::DEFAULT_MAX_FRAME,
    parameter int AddrW    = $clog2(MaxFrame),
    parameter int CountW   = $clog2(MaxFrame + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [lfbr_pkg::REQ_W-1:0]    req_type,
    input  logic [lfbr_pkg::BYTE_W-1:0]   data_byte,
    input  logic [lfbr_pkg::INDEX_W-1:0]  read_index,
    input  lfbr_pkg::cfg_t                cfg,
    output logic                          wr_en,
    output logic [AddrW-1:0]              wr_addr,
    output logic [lfbr_pkg::BYTE_W-1:0]   wr_data,
    output logic                          rd_en,
    output lfbr_pkg::result_t             result
);
    import lfbr_pkg::*;

    typedef enum logic [1:0] {
        PH_SYNC   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [CountW-1:0]   count_reg, count_next;
    logic [CountW-1:0]   exp_reg, exp_next;
    logic                waiting_reg, waiting_next;
    logic [IDLE_W-1:0]   idle_reg, idle_next;
    logic                complete_reg, complete_next;
    logic [CountW-1:0]   done_reg, done_next;
    logic [BYTE_W-1:0]   len_low_reg, len_low_next;

    logic [2*BYTE_W-1:0] len;
    logic                check_end;

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        exp_next      = exp_reg;
        waiting_next  = waiting_reg;
        idle_next     = idle_reg;
        complete_next = complete_reg;
        done_next     = done_reg;
        len_low_next  = len_low_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[AddrW-1:0];
        wr_data       = data_byte;
        rd_en         = 1'b0;
        result        = '0;
        check_end     = 1'b0;
        len           = {data_byte, len_low_reg};

        if (accept)
        begin
            case (req_type)
                REQ_BYTE:
                begin
                    if (!complete_reg)
                    begin
                        waiting_next = 1'b1;
                        idle_next    = '0;
                        // A byte arriving on a full buffer restarts the frame with it.
                        if (count_reg >= CountW'(MaxFrame))
                        begin
                            count_next   = '0;
                            exp_next     = '0;
                            idle_next    = '0;
                            waiting_next = 1'b0;
                            phase_next   = PH_SYNC;
                        end
                        wr_en   = 1'b1;
                        wr_addr = count_next[AddrW-1:0];
                        if (count_next == CountW'(LEN_LOW_POS))
                        begin
                            len_low_next = data_byte;
                        end
                        count_next = count_next + CountW'(1);

                        case (phase_next)
                            PH_SYNC:
                            begin
                                if (count_next == CountW'(1))
                                begin
                                    if (data_byte != cfg.first_sync)
                                    begin
                                        count_next   = '0;
                                        exp_next     = '0;
                                        idle_next    = '0;
                                        waiting_next = 1'b0;
                                        phase_next   = PH_SYNC;
                                    end
                                end
                                else if (count_next == CountW'(2))
                                begin
                                    if (data_byte != cfg.second_sync)
                                    begin
                                        count_next   = '0;
                                        exp_next     = '0;
                                        idle_next    = '0;
                                        waiting_next = 1'b0;
                                        phase_next   = PH_SYNC;
                                    end
                                    else
                                    begin
                                        phase_next = PH_HEADER;
                                    end
                                end
                            end
                            PH_HEADER:
                            begin
                                if (count_next >= CountW'(HEADER_BYTES))
                                begin
                                    if ((len < {{(BYTE_W+1){1'b0}}, cfg.min_length}) ||
                                        ({16'd0, len} > 32'(MaxFrame)))
                                    begin
                                        count_next   = '0;
                                        exp_next     = '0;
                                        idle_next    = '0;
                                        waiting_next = 1'b0;
                                        phase_next   = PH_SYNC;
                                    end
                                    else
                                    begin
                                        phase_next = PH_BODY;
                                        exp_next   = CountW'(len);
                                        check_end  = 1'b1;
                                    end
                                end
                            end
                            PH_BODY:
                            begin
                                check_end = 1'b1;
                            end
                            default: ;
                        endcase

                        if (check_end)
                        begin
                            if (count_next == exp_next)
                            begin
                                complete_next = 1'b1;
                                done_next     = count_next;
                                count_next    = '0;
                                exp_next      = '0;
                                idle_next     = '0;
                                waiting_next  = 1'b0;
                                phase_next    = PH_SYNC;
                            end
                            else if (count_next > exp_next)
                            begin
                                count_next   = '0;
                                exp_next     = '0;
                                idle_next    = '0;
                                waiting_next = 1'b0;
                                phase_next   = PH_SYNC;
                            end
                        end
                    end
                end
                REQ_POLL:
                begin
                    if (waiting_reg)
                    begin
                        // The clear resets the idle count before this poll is counted.
                        if (idle_reg >= {1'b0, cfg.timeout})
                        begin
                            count_next   = '0;
                            exp_next     = '0;
                            idle_next    = '0;
                            waiting_next = 1'b0;
                            phase_next   = PH_SYNC;
                        end
                        if (idle_next < IDLE_MAX)
                        begin
                            idle_next = idle_next + IDLE_W'(1);
                        end
                    end
                    else
                    begin
                        count_next   = '0;
                        exp_next     = '0;
                        idle_next    = '0;
                        waiting_next = 1'b0;
                        phase_next   = PH_SYNC;
                    end
                    if (complete_reg)
                    begin
                        waiting_next        = 1'b0;
                        complete_next       = 1'b0;
                        result.frame_ready  = 1'b1;
                        result.frame_length = LENGTH_W'(done_reg);
                    end
                end
                REQ_READ:
                begin
                    rd_en         = 1'b1;
                    result.rd_sel = ({26'd0, read_index} < 32'(MaxFrame));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SYNC;
            count_reg    <= '0;
            exp_reg      <= '0;
            waiting_reg  <= 1'b0;
            idle_reg     <= '0;
            complete_reg <= 1'b0;
            done_reg     <= '0;
            len_low_reg  <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            exp_reg      <= exp_next;
            waiting_reg  <= waiting_next;
            idle_reg     <= idle_next;
            complete_reg <= complete_next;
            done_reg     <= done_next;
            len_low_reg  <= len_low_next;
        end
    end

endmodule

// File: src/length_framed_byte_receiver_top.sv
// Top level of the length-framed byte receiver: handshakes and result register.
// Depends on lfbr_pkg, lfbr_cfg, lfbr_ctrl and lfbr_buf.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   in       | in_valid/in_ready  | req_type, data_byte, read_index
//   out      | out_valid/out_ready| frame_ready, frame_length, read_data
//   cfg      | cfg_we             | cfg_index, cfg_data
//
// Each request updates the frame state and the buffer at the edge where it is
// accepted, and its result sits in the output register from the next cycle on.
// A new request is taken each cycle while the output register is empty or being
// drained. A stalled result holds its value.
// Reset clears the frame state at once; buffer contents are not initialized.
module length_framed_byte_receiver_top #(
    parameter int MaxFrame = lfbr_pkg::DEFAULT_MAX_FRAME
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lfbr_pkg::REQ_W-1:0]        req_type,
    input  logic [lfbr_pkg::BYTE_W-1:0]       data_byte,
    input  logic [lfbr_pkg::INDEX_W-1:0]      read_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              frame_ready,
    output logic [lfbr_pkg::LENGTH_W-1:0]     frame_length,
    output logic [lfbr_pkg::BYTE_W-1:0]       read_data,
    input  logic                              cfg_we,
    input  logic [lfbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lfbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lfbr_pkg::*;

    localparam int AddrW  = $clog2(MaxFrame);
    localparam int CountW = $clog2(MaxFrame + 1);

    cfg_t              cfg;
    result_t           result;
    result_t           result_reg;
    logic              out_valid_reg;
    logic              accept;
    logic              wr_en;
    logic [AddrW-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_data;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    lfbr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfbr_ctrl #(
        .MaxFrame (MaxFrame),
        .AddrW    (AddrW),
        .CountW   (CountW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .data_byte  (data_byte),
        .read_index (read_index),
        .cfg        (cfg),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .result     (result)
    );

    lfbr_buf #(
        .MaxFrame (MaxFrame),
        .AddrW    (AddrW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (AddrW'(read_index)),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_ready  = result_reg.frame_ready;
    assign frame_length = result_reg.frame_length;
    // The buffer read port holds its data until the next read request.
    assign read_data    = result_reg.rd_sel ? rd_data : '0;

endmodule

// File: test/tb_length_framed_byte_receiver_top.sv
// Self-checking testbench for length_framed_byte_receiver_top: directed and random requests.
// Depends on lfbr_pkg and the top level; a behavioral model of the receiver predicts each reply.
module tb_length_framed_byte_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfbr_pkg::*;

    localparam int FRAME_CAP   = DEFAULT_MAX_FRAME;
    localparam int CYCLE_LIMIT = 500000;

    // The request code the block must leave without effect.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic                frame_ready;
        logic [LENGTH_W-1:0] frame_length;
        logic [BYTE_W-1:0]   read_data;
    } reply_t;

    typedef enum logic [1:0] {
        HUNT_SYNC,
        READ_HEADER,
        READ_BODY
    } rx_phase_t;

    typedef enum int {
        GOOD_FRAME,
        BAD_SYNC,
        BAD_LENGTH,
        CUT_SHORT
    } attempt_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_LONG_STALLS
    } stall_mode_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic [REQ_W-1:0]       req_type   = '0;
    logic [BYTE_W-1:0]      data_byte  = '0;
    logic [INDEX_W-1:0]     read_index = '0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic                   frame_ready;
    logic [LENGTH_W-1:0]    frame_length;
    logic [BYTE_W-1:0]      read_data;
    logic                   cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;

    length_framed_byte_receiver_top DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver state as the block should hold it.
    cfg_t                model_cfg;
    rx_phase_t           model_phase;
    logic [LENGTH_W-1:0] model_count;
    logic [LENGTH_W-1:0] model_expected;
    logic [LENGTH_W-1:0] model_done_length;
    logic                model_waiting;
    logic                model_complete;
    logic [IDLE_W-1:0]   model_idle_polls;
    logic [BYTE_W-1:0]   model_buffer [FRAME_CAP];
    bit                  entry_written [FRAME_CAP];

    reply_t      awaited_replies [$];
    int          failures    = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int unsigned cycle_count = 0;

    function automatic logic [BYTE_W-1:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [INDEX_W-1:0] any_index();
        return 6'($urandom_range(0, FRAME_CAP - 1));
    endfunction

    function automatic void drop_partial_frame();
        model_phase      = HUNT_SYNC;
        model_count      = '0;
        model_expected   = '0;
        model_idle_polls = '0;
        model_waiting    = 1'b0;
    endfunction

    function automatic void check_frame_end();
        if (model_count == model_expected)
        begin
            model_complete    = 1'b1;
            model_done_length = model_count;
            drop_partial_frame();
        end
        else if (model_count > model_expected)
        begin
            drop_partial_frame();
        end
    endfunction

    function automatic reply_t predict_reply(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] d,
                                             logic [INDEX_W-1:0] idx);
        reply_t r;
        logic [15:0] len;
        r = '0;
        case (req)
            REQ_BYTE:
            begin
                // A held frame blocks every new byte until it is polled away.
                if (!model_complete)
                begin
                    model_waiting    = 1'b1;
                    model_idle_polls = '0;
                    if (model_count >= 7'(FRAME_CAP))
                        drop_partial_frame();
                    model_buffer[model_count[INDEX_W-1:0]]  = d;
                    entry_written[model_count[INDEX_W-1:0]] = 1'b1;
                    model_count = model_count + 1'b1;
                    case (model_phase)
                        HUNT_SYNC:
                        begin
                            if (model_count == 7'd1 && d != model_cfg.first_sync)
                                drop_partial_frame();
                            else if (model_count == 7'd2)
                            begin
                                if (d != model_cfg.second_sync)
                                    drop_partial_frame();
                                else
                                    model_phase = READ_HEADER;
                            end
                        end
                        READ_HEADER:
                        begin
                            if (model_count >= 7'(HEADER_BYTES))
                            begin
                                len = {model_buffer[LEN_LOW_POS + 1], model_buffer[LEN_LOW_POS]};
                                if (len < {9'd0, model_cfg.min_length} || len > 16'(FRAME_CAP))
                                    drop_partial_frame();
                                else
                                begin
                                    model_phase    = READ_BODY;
                                    model_expected = len[LENGTH_W-1:0];
                                    check_frame_end();
                                end
                            end
                        end
                        default: check_frame_end();
                    endcase
                end
            end
            REQ_POLL:
            begin
                if (model_waiting)
                begin
                    if (model_idle_polls >= {1'b0, model_cfg.timeout})
                        drop_partial_frame();
                    if (model_idle_polls < IDLE_MAX)
                        model_idle_polls = model_idle_polls + 1'b1;
                end
                else
                begin
                    drop_partial_frame();
                end
                if (model_complete)
                begin
                    model_waiting   = 1'b0;
                    model_complete  = 1'b0;
                    r.frame_ready   = 1'b1;
                    r.frame_length  = model_done_length;
                end
            end
            // The six-bit index cannot reach past the buffer.
            REQ_READ: r.read_data = model_buffer[idx];
            default: ;
        endcase
        return r;
    endfunction

    // One request on the input channel; the sender runs in bursts with gaps between them.
    task automatic send_request(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] d,
                                logic [INDEX_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        req_type   <= req;
        data_byte  <= d;
        read_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        awaited_replies.push_back(predict_reply(req, d, idx));
        items_sent++;
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] d);
        send_request(REQ_BYTE, d, any_index());
    endtask

    task automatic send_poll();
        send_request(REQ_POLL, any_byte(), any_index());
    endtask

    // Reads only entries written since reset; entry 0 is the first one ever written.
    task automatic send_read();
        logic [INDEX_W-1:0] idx;
        if (!entry_written[0])
        begin
            send_poll();
            return;
        end
        idx = any_index();
        while (!entry_written[idx])
            idx = any_index();
        send_request(REQ_READ, any_byte(), idx);
    endtask

    task automatic wait_all_replies();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(logic [BYTE_W-1:0] first, logic [BYTE_W-1:0] second,
                                 logic [LENGTH_W-1:0] min_len, logic [TIMEOUT_W-1:0] limit);
        wait_all_replies();
        write_register(CFG_FIRST_SYNC, {8'd0, first});
        write_register(CFG_SECOND_SYNC, {8'd0, second});
        write_register(CFG_MIN_LENGTH, {9'd0, min_len});
        write_register(CFG_TIMEOUT, limit);
        cfg_we <= 1'b0;
        model_cfg = '{first_sync: first, second_sync: second, min_length: min_len,
                      timeout: limit};
    endtask

    task automatic send_frame_attempt(attempt_t kind);
        int len;
        int keep;
        logic [BYTE_W-1:0] frame [$];
        if (kind == BAD_LENGTH)
        begin
            case ($urandom_range(0, 2))
                0: len = $urandom_range(0, model_cfg.min_length - 1);
                1: len = $urandom_range(FRAME_CAP + 1, 255);
                default: len = $urandom_range(256, 65535);
            endcase
        end
        else if ($urandom_range(0, 3) != 0)
        begin
            len = model_cfg.min_length + $urandom_range(0, 6);
        end
        else
        begin
            len = $urandom_range(model_cfg.min_length, FRAME_CAP);
        end
        if (kind != BAD_LENGTH && len > FRAME_CAP)
            len = FRAME_CAP;

        frame.push_back(model_cfg.first_sync);
        frame.push_back(model_cfg.second_sync);
        frame.push_back(any_byte());
        frame.push_back(8'(len));
        frame.push_back(8'(len >> 8));
        if (kind == BAD_SYNC)
        begin
            if ($urandom_range(0, 1) == 0)
                frame[0] = frame[0] ^ 8'($urandom_range(1, 255));
            else
                frame[1] = frame[1] ^ 8'($urandom_range(1, 255));
        end
        if (kind == GOOD_FRAME || kind == CUT_SHORT)
        begin
            while (frame.size() < len)
                frame.push_back(any_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 3)) frame.push_back(any_byte());
        end
        if (kind == CUT_SHORT)
        begin
            keep = $urandom_range(1, len - 1);
            while (frame.size() > keep)
                void'(frame.pop_back());
        end

        foreach (frame[i])
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_poll();
                else
                    send_read();
            end
            send_byte(frame[i]);
        end

        // With a short limit, poll until the partial frame times out.
        if (kind == CUT_SHORT && model_cfg.timeout < 16)
            repeat (int'(model_cfg.timeout) + 1) send_poll();
        if ($urandom_range(0, 4) == 0)
            send_byte(any_byte());
        if ($urandom_range(0, 9) != 0)
            send_poll();
        repeat ($urandom_range(0, 2)) send_read();
    endtask

    task automatic run_traffic_phase(logic [BYTE_W-1:0] first, logic [BYTE_W-1:0] second,
                                     logic [LENGTH_W-1:0] min_len,
                                     logic [TIMEOUT_W-1:0] limit, int count);
        int start;
        int pick;
        bit drained_midway;
        load_settings(first, second, min_len, limit);
        start = items_sent;
        drained_midway = 1'b0;
        while (items_sent - start < count)
        begin
            if (!drained_midway && items_sent - start >= count / 2)
            begin
                wait_all_replies();
                drained_midway = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_frame_attempt(GOOD_FRAME);
            else if (pick < 70)
                send_frame_attempt(BAD_SYNC);
            else if (pick < 78)
                send_frame_attempt(BAD_LENGTH);
            else if (pick < 88)
                send_frame_attempt(CUT_SHORT);
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    if ($urandom_range(0, 2) == 0)
                        send_read();
                    else
                        send_request(($urandom_range(0, 1) == 0) ? REQ_POLL : REQ_BYTE,
                                     any_byte(), any_index());
                end
            end
        end
    endtask

    task automatic test_reset_settings();
        send_byte(RST_FIRST_SYNC);
        send_byte(RST_SECOND_SYNC);
        send_byte(8'h00);
        send_byte(8'd6);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_poll();
        send_request(REQ_READ, any_byte(), 6'd0);
        send_request(REQ_READ, any_byte(), 6'd5);
    endtask

    // A length equal to the header size completes the frame at the fifth byte.
    task automatic test_header_sized_frame();
        load_settings(RST_FIRST_SYNC, RST_SECOND_SYNC, 7'd5, RST_TIMEOUT);
        send_byte(RST_FIRST_SYNC);
        send_byte(RST_SECOND_SYNC);
        send_byte(any_byte());
        send_byte(8'd5);
        send_byte(8'd0);
        send_byte(8'hFF);
        send_request(REQ_UNUSED, any_byte(), any_index());
        send_poll();
        send_poll();
    endtask

    // A limit of zero drops a partial frame at the first poll after a byte.
    task automatic test_zero_timeout();
        load_settings(8'h00, 8'hFF, 7'd64, 16'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_poll();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(any_byte());
        send_poll();
    endtask

    task automatic test_tight_timeout();
        run_traffic_phase(8'h00, 8'hFF, 7'd5, 16'd1, 250);
    endtask

    task automatic test_long_frames();
        run_traffic_phase(8'hFF, 8'h00, 7'd64, 16'hFFFF, 200);
    endtask

    task automatic test_random_settings();
        run_traffic_phase(any_byte(), any_byte(), 7'($urandom_range(5, 12)),
                          16'($urandom_range(1, 12)), 300);
        run_traffic_phase(any_byte(), any_byte(), 7'($urandom_range(5, 20)),
                          16'($urandom_range(2, 10)), 300);
        run_traffic_phase(any_byte(), any_byte(), 7'($urandom_range(5, 64)),
                          16'($urandom_range(1, 65535)), 250);
    endtask

    // Output stalls: out_ready follows one of four patterns, picked anew at random.
    stall_mode_t stall_mode = READY_ALWAYS;
    int          stall_span = 0;
    int          stall_hold = 0;
    int          stall_tick = 0;

    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_span = $urandom_range(40, 300);
        end
        else
        begin
            stall_span--;
        end
        stall_tick++;
        case (stall_mode)
            READY_ALWAYS: out_ready <= 1'b1;
            READY_COIN: out_ready <= 1'($urandom_range(0, 1));
            READY_PERIODIC: out_ready <= (stall_tick % 7) >= 3;
            default:
            begin
                if (stall_hold > 0)
                begin
                    stall_hold--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 9) == 0)
                        stall_hold = $urandom_range(4, 12);
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("reply with no request waiting for it");
                failures++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (frame_ready !== want.frame_ready)
                begin
                    $error("frame_ready: expected %0d, got %0d", want.frame_ready, frame_ready);
                    failures++;
                end
                if (frame_length !== want.frame_length)
                begin
                    $error("frame_length: expected %0d, got %0d",
                           want.frame_length, frame_length);
                    failures++;
                end
                if (read_data !== want.read_data)
                begin
                    $error("read_data: expected 0x%02h, got 0x%02h", want.read_data, read_data);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        model_cfg = '{first_sync: RST_FIRST_SYNC, second_sync: RST_SECOND_SYNC,
                      min_length: RST_MIN_LENGTH, timeout: RST_TIMEOUT};
        drop_partial_frame();
        model_complete    = 1'b0;
        model_done_length = '0;
        foreach (entry_written[i])
            entry_written[i] = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_header_sized_frame();
        test_zero_timeout();
        test_tight_timeout();
        test_long_frames();
        test_random_settings();

        wait_all_replies();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
src/lfbr_pkg.sv
src/lfbr_cfg.sv
src/lfbr_buf.sv
src/lfbr_ctrl.sv
src/length_framed_byte_receiver_top.sv
test/tb_length_framed_byte_receiver_top.sv
